/* rtl/uvs_pkg.sv */
// Shared types, constants and fixed-point helpers for the UV sphere tessellator.
// No dependencies; imported by uvs_sine and uv_sphere_tessellator_unit.
package uvs_pkg;

    // Field and register widths
    localparam int IDX_W = 16;
    localparam int RAD_W = 16;
    localparam int SEG_W = 8;
    localparam int CFG_W = 16;
    localparam int POS_W = 17;
    localparam int TEX_W = 16;

    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [SEG_W-1:0] SEG_RST    = 8'd16;
    localparam logic [SEG_W-1:0] SEG_MIN    = 8'd2;

    typedef enum logic {
        FUNC_VERTEX = 1'b0,
        FUNC_QUAD   = 1'b1
    } t_func;

    typedef enum logic {
        CFG_RADIUS   = 1'b0,
        CFG_SEGMENTS = 1'b1
    } t_cfg_reg;

    // Q30 fixed point
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [29:0] Q30_HALF = 30'h2000_0000;

    // sin(t*pi/2) odd polynomial, coefficients from t^11 down to t^1
    localparam int SIN_HORNER = 5;
    localparam int SIN_LAT    = SIN_HORNER + 3;
    localparam logic [30:0] SIN_COEF [SIN_HORNER+1] = '{
        31'd3864, 31'd172272, 31'd5026995,
        31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Cycles from a start transfer to its result strobe
    localparam int LATENCY = 26;

    // round(a*b / 2^30) on Q30 magnitudes
    function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
        logic [61:0] acc;
        acc = a * b + {32'd0, Q30_HALF};
        return acc[60:30];
    endfunction

    // round(r*w / 2^30), radius times Q30 magnitude
    function automatic logic [16:0] mul_rad(logic [RAD_W-1:0] r, logic [30:0] w);
        logic [46:0] acc;
        acc = r * w + {17'd0, Q30_HALF};
        return acc[46:30];
    endfunction

endpackage

/* rtl/uv_sphere_tessellator_unit.sv */
// UV sphere tessellator top level: vertex positions, texture coordinates, quad indices.
// Depends on uvs_pkg and uvs_sine.
//
// Usage
//   Request channel: an item (i_func, i_item_index) transfers at a rising edge where
//   start is high and busy is low. busy is low at all times after reset, so a new
//   item may transfer on every clock cycle.
//   Result channel: o_valid is high for exactly one cycle with the result fields;
//   the result transfers at the edge that ends that cycle. The receiver cannot stall.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 radius,
//   1 segment count) at the edge. Write only while no request is in flight.
// Timing
//   Throughput is one item per cycle; the pipeline never stalls.
//   The depth is set by the 33-step long division of the azimuth phase
//   (nine stages of four radix-2 steps) and the eight-stage sine polynomial.
// Reset
//   i_rst_n low (synchronous) empties the pipeline, holds busy high and restores
//   radius 256 and 16 segments. busy drops on the first edge after reset is released.
module uv_sphere_tessellator_unit import uvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_func,
    input  logic [IDX_W-1:0]        i_item_index,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [TEX_W-1:0]        o_tex_u,
    output logic [TEX_W-1:0]        o_tex_v,
    output logic [IDX_W-1:0]        o_corner_0,
    output logic [IDX_W-1:0]        o_corner_1,
    output logic [IDX_W-1:0]        o_corner_2,
    output logic [IDX_W-1:0]        o_corner_3,
    output logic [IDX_W-1:0]        o_corner_4,
    output logic [IDX_W-1:0]        o_corner_5,
    output logic                    o_out_of_range
);

    // Integer division: 8 quotient bits, two per stage
    localparam int QUO_W   = 8;
    localparam int ID_STEP = 2;
    localparam int ID_ST   = QUO_W / ID_STEP;

    // Fractional divisions: azimuth, polar, u, v
    localparam int NCH     = 4;
    localparam int CH_AZ   = 0;
    localparam int CH_POL  = 1;
    localparam int CH_U    = 2;
    localparam int CH_V    = 3;
    localparam int CH_K [NCH] = '{32, 31, 15, 15};
    localparam int FD_QW   = 33;
    localparam int FD_STEP = 4;
    localparam int FD_ST   = (FD_QW + FD_STEP - 1) / FD_STEP;

    typedef struct packed {
        t_func             func;
        logic              oor;
        logic [8:0]        div;
        logic [IDX_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } t_id;

    typedef struct packed {
        t_func                         func;
        logic                          oor;
        logic [7:0]                    col;
        logic [7:0]                    row;
        logic [NCH-1:0][7:0]           rem;
        logic [NCH-1:0][FD_QW-1:0]     quo;
    } t_fd;

    typedef struct packed {
        t_func             func;
        logic              oor;
        logic [7:0]        col;
        logic [7:0]        row;
        logic [TEX_W-1:0]  tex_u;
        logic [TEX_W-1:0]  tex_v;
    } t_tail;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] r_radius;
    logic [SEG_W-1:0] r_segments;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_segments <= SEG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_SEGMENTS: r_segments <= i_cfg_data[SEG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective segment count and vertices per row
    logic [7:0] s_eff;
    logic [8:0] cnt;
    logic [31:0] hvec;

    assign s_eff = (r_segments < SEG_MIN) ? SEG_MIN : r_segments;
    assign cnt   = {1'b0, s_eff} + 9'd1;
    // Rounding offset s/2 as the low bits of each fractional numerator
    assign hvec  = {25'd0, s_eff[7:1]};

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    logic              r_busy;
    logic              r_a_valid;
    t_func             r_a_func;
    logic [IDX_W-1:0]  r_a_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_a_valid <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_a_valid <= start & ~r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_func <= t_func'(i_func);
        r_a_idx  <= i_item_index;
    end

    assign busy = r_busy;

    // Divisor and range check: vertices use S+1 per row, quads S
    logic [8:0]  a_div;
    logic [17:0] a_lim;
    logic        a_oor;

    assign a_div = (r_a_func == FUNC_QUAD) ? {1'b0, s_eff} : cnt;
    assign a_lim = a_div * a_div;
    assign a_oor = {2'b00, r_a_idx} >= a_lim;

    // ------------------------------------------------------------------
    // Integer division of the index: column and row
    // ------------------------------------------------------------------
    t_id  r_id   [ID_ST+1];
    logic r_id_v [ID_ST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_id_v[0] <= 1'b0;
        else          r_id_v[0] <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        r_id[0].func <= r_a_func;
        r_id[0].oor  <= a_oor;
        r_id[0].div  <= a_div;
        r_id[0].rem  <= r_a_idx;
        r_id[0].quo  <= '0;
    end

    for (genvar g = 1; g <= ID_ST; g++) begin : g_id
        t_id n_id;

        // Two restoring steps, quotient bits from the top down
        always_comb begin
            logic [16:0] dsh;
            n_id = r_id[g-1];
            for (int m = 0; m < ID_STEP; m++) begin
                dsh = {8'd0, n_id.div} << (QUO_W - 1 - (g - 1) * ID_STEP - m);
                if ({1'b0, n_id.rem} >= dsh) begin
                    n_id.rem = n_id.rem - dsh[IDX_W-1:0];
                    n_id.quo[3'(QUO_W - 1 - (g - 1) * ID_STEP - m)] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_id_v[g] <= 1'b0;
            else          r_id_v[g] <= r_id_v[g-1];
        end

        always_ff @(posedge i_clk) begin
            r_id[g] <= n_id;
        end
    end

    // ------------------------------------------------------------------
    // Fractional divisions: round(X * 2^K / S) as long division
    // ------------------------------------------------------------------
    t_fd  fd_in;
    t_fd  r_fd   [1:FD_ST];
    logic r_fd_v [1:FD_ST];

    always_comb begin
        fd_in      = '0;
        fd_in.func = r_id[ID_ST].func;
        fd_in.oor  = r_id[ID_ST].oor;
        fd_in.col  = r_id[ID_ST].rem[7:0];
        fd_in.row  = r_id[ID_ST].quo;
        fd_in.rem[CH_AZ]  = r_id[ID_ST].rem[7:0];
        fd_in.rem[CH_POL] = r_id[ID_ST].quo;
        fd_in.rem[CH_U]   = r_id[ID_ST].rem[7:0];
        fd_in.rem[CH_V]   = r_id[ID_ST].quo;
    end

    for (genvar g = 1; g <= FD_ST; g++) begin : g_fd
        t_fd  src;
        t_fd  n_fd;
        logic src_v;

        if (g == 1) begin : g_first
            assign src   = fd_in;
            assign src_v = r_id_v[ID_ST];
        end else begin : g_next
            assign src   = r_fd[g-1];
            assign src_v = r_fd_v[g-1];
        end

        // Step 0 compares the integer part; later steps bring in one numerator bit
        always_comb begin
            int         j;
            logic [8:0] tmp;
            logic       qb;
            n_fd = src;
            for (int c = 0; c < NCH; c++) begin
                for (int m = 0; m < FD_STEP; m++) begin
                    j = (g - 1) * FD_STEP + m;
                    if (j <= CH_K[c]) begin
                        if (j == 0) tmp = {1'b0, n_fd.rem[c]};
                        else        tmp = {n_fd.rem[c], hvec[5'(CH_K[c] - j)]};
                        qb = (tmp >= {1'b0, s_eff});
                        if (qb) tmp = tmp - {1'b0, s_eff};
                        n_fd.rem[c] = tmp[7:0];
                        n_fd.quo[c] = {n_fd.quo[c][FD_QW-2:0], qb};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_fd_v[g] <= 1'b0;
            else          r_fd_v[g] <= src_v;
        end

        always_ff @(posedge i_clk) begin
            r_fd[g] <= n_fd;
        end
    end

    // ------------------------------------------------------------------
    // Sine lanes: sin/cos of azimuth and polar angle
    // ------------------------------------------------------------------
    logic [31:0] ph_az, ph_pol;
    logic [30:0] sa_mag, ca_mag, sp_mag, cp_mag;
    logic        sa_neg, ca_neg, sp_neg, cp_neg;

    assign ph_az  = r_fd[FD_ST].quo[CH_AZ][31:0];
    assign ph_pol = r_fd[FD_ST].quo[CH_POL][31:0];

    uvs_sine u_sin_az (
        .i_clk   (i_clk),
        .i_phase (ph_az),
        .o_mag   (sa_mag),
        .o_neg   (sa_neg)
    );

    uvs_sine u_cos_az (
        .i_clk   (i_clk),
        .i_phase (ph_az + 32'h4000_0000),
        .o_mag   (ca_mag),
        .o_neg   (ca_neg)
    );

    uvs_sine u_sin_pol (
        .i_clk   (i_clk),
        .i_phase (ph_pol),
        .o_mag   (sp_mag),
        .o_neg   (sp_neg)
    );

    uvs_sine u_cos_pol (
        .i_clk   (i_clk),
        .i_phase (ph_pol + 32'h4000_0000),
        .o_mag   (cp_mag),
        .o_neg   (cp_neg)
    );

    // Hold item details alongside the sine lanes
    t_tail r_tl   [1:SIN_LAT];
    logic  r_tl_v [1:SIN_LAT];

    for (genvar g = 1; g <= SIN_LAT; g++) begin : g_tl
        if (g == 1) begin : g_load
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_tl_v[g] <= 1'b0;
                else          r_tl_v[g] <= r_fd_v[FD_ST];
            end

            always_ff @(posedge i_clk) begin
                r_tl[g].func  <= r_fd[FD_ST].func;
                r_tl[g].oor   <= r_fd[FD_ST].oor;
                r_tl[g].col   <= r_fd[FD_ST].col;
                r_tl[g].row   <= r_fd[FD_ST].row;
                r_tl[g].tex_u <= r_fd[FD_ST].quo[CH_U][TEX_W-1:0];
                r_tl[g].tex_v <= r_fd[FD_ST].quo[CH_V][TEX_W-1:0];
            end
        end else begin : g_move
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_tl_v[g] <= 1'b0;
                else          r_tl_v[g] <= r_tl_v[g-1];
            end

            always_ff @(posedge i_clk) begin
                r_tl[g] <= r_tl[g-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Combine: ring radius terms, then scale by the sphere radius
    // ------------------------------------------------------------------
    logic        r_m1_v;
    t_tail       r_m1_tl;
    logic [30:0] r_m1_wx, r_m1_wz, r_m1_cp;
    logic        r_m1_nx, r_m1_ny, r_m1_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m1_v <= 1'b0;
        else          r_m1_v <= r_tl_v[SIN_LAT];
    end

    always_ff @(posedge i_clk) begin
        r_m1_tl <= r_tl[SIN_LAT];
        r_m1_wx <= mul_q30(ca_mag, sp_mag);
        r_m1_wz <= mul_q30(sa_mag, sp_mag);
        r_m1_cp <= cp_mag;
        // x is the negated product
        r_m1_nx <= (ca_neg == sp_neg);
        r_m1_ny <= cp_neg;
        r_m1_nz <= sa_neg ^ sp_neg;
    end

    logic             r_m2_v;
    t_tail            r_m2_tl;
    logic [16:0]      r_m2_mx, r_m2_my, r_m2_mz;
    logic             r_m2_nx, r_m2_ny, r_m2_nz;
    logic [IDX_W-1:0] r_m2_a;
    logic [16:0]      m2_a;

    assign m2_a = r_m1_tl.row * cnt + {9'd0, r_m1_tl.col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m2_v <= 1'b0;
        else          r_m2_v <= r_m1_v;
    end

    always_ff @(posedge i_clk) begin
        r_m2_tl <= r_m1_tl;
        r_m2_mx <= mul_rad(r_radius, r_m1_wx);
        r_m2_my <= mul_rad(r_radius, r_m1_cp);
        r_m2_mz <= mul_rad(r_radius, r_m1_wz);
        r_m2_nx <= r_m1_nx;
        r_m2_ny <= r_m1_ny;
        r_m2_nz <= r_m1_nz;
        r_m2_a  <= m2_a[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                    r_out_v;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [TEX_W-1:0]        r_tex_u, r_tex_v;
    logic [IDX_W-1:0]        r_c0, r_c1, r_c2, r_c3, r_c4, r_c5;
    logic                    r_oor;

    logic signed [POS_W-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic [TEX_W-1:0]        n_tex_u, n_tex_v;
    logic [IDX_W-1:0]        n_a, n_b, n_c, n_d;
    logic                    n_vtx, n_quad;

    always_comb begin
        n_vtx   = (r_m2_tl.func == FUNC_VERTEX) && !r_m2_tl.oor;
        n_quad  = (r_m2_tl.func == FUNC_QUAD) && !r_m2_tl.oor;
        n_pos_x = '0;
        n_pos_y = '0;
        n_pos_z = '0;
        n_tex_u = '0;
        n_tex_v = '0;
        n_a     = '0;
        n_b     = '0;
        n_c     = '0;
        n_d     = '0;
        if (n_vtx) begin
            n_pos_x = r_m2_nx ? (17'd0 - r_m2_mx) : r_m2_mx;
            n_pos_y = r_m2_ny ? (17'd0 - r_m2_my) : r_m2_my;
            n_pos_z = r_m2_nz ? (17'd0 - r_m2_mz) : r_m2_mz;
            n_tex_u = r_m2_tl.tex_u;
            n_tex_v = r_m2_tl.tex_v;
        end
        if (n_quad) begin
            n_a = r_m2_a;
            n_b = r_m2_a + 16'd1;
            n_c = r_m2_a + {7'd0, cnt};
            n_d = n_c + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else          r_out_v <= r_m2_v;
    end

    // Corner order b, a, d, a, c, d
    always_ff @(posedge i_clk) begin
        r_pos_x <= n_pos_x;
        r_pos_y <= n_pos_y;
        r_pos_z <= n_pos_z;
        r_tex_u <= n_tex_u;
        r_tex_v <= n_tex_v;
        r_c0    <= n_b;
        r_c1    <= n_a;
        r_c2    <= n_d;
        r_c3    <= n_a;
        r_c4    <= n_c;
        r_c5    <= n_d;
        r_oor   <= r_m2_tl.oor;
    end

    assign o_valid        = r_out_v;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;
    assign o_tex_u        = r_tex_u;
    assign o_tex_v        = r_tex_v;
    assign o_corner_0     = r_c0;
    assign o_corner_1     = r_c1;
    assign o_corner_2     = r_c2;
    assign o_corner_3     = r_c3;
    assign o_corner_4     = r_c4;
    assign o_corner_5     = r_c5;
    assign o_out_of_range = r_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("transfer produced no result at fixed latency");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transfer");

    a_tex_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tex_u <= 16'd32768) && (o_tex_v <= 16'd32768))
        else $error("texture coordinate above one");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_pos_x == '0) && (o_pos_y == '0)
            && (o_pos_z == '0) && (o_tex_u == '0) && (o_corner_0 == '0)
            && (o_corner_4 == '0))
        else $error("out-of-range result carries data");

    a_pos_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_pos_y) <= $signed({1'b0, r_radius}))
            && ($signed(o_pos_y) >= -$signed({1'b0, r_radius})))
        else $error("vertex height beyond sphere radius");

endmodule

/* rtl/uvs_sine.sv */
// Pipelined fixed-point sine of a 32-bit phase (units of 2^-32 turn).
// Depends on uvs_pkg for the polynomial coefficients and the Horner step count.
module uvs_sine import uvs_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_phase,
    output logic [30:0] o_mag,
    output logic        o_neg
);

    typedef struct packed {
        logic [30:0] t;
        logic [30:0] t2;
        logic [30:0] p;
        logic        neg;
    } t_sin_st;

    t_sin_st     r_st [SIN_HORNER+2];
    logic [30:0] r_mag;
    logic        r_neg;

    // Fold the phase onto a quarter turn
    always_ff @(posedge i_clk) begin
        r_st[0].t   <= i_phase[30] ? (Q30_ONE - {1'b0, i_phase[29:0]})
                                   : {1'b0, i_phase[29:0]};
        r_st[0].t2  <= '0;
        r_st[0].p   <= '0;
        r_st[0].neg <= i_phase[31];
    end

    for (genvar k = 1; k <= SIN_HORNER + 1; k++) begin : g_st
        logic [61:0] prod;
        if (k == 1) begin : g_sq
            assign prod = r_st[0].t * r_st[0].t;
            always_ff @(posedge i_clk) begin
                r_st[k].t   <= r_st[0].t;
                r_st[k].t2  <= prod[60:30];
                r_st[k].p   <= SIN_COEF[0];
                r_st[k].neg <= r_st[0].neg;
            end
        end else begin : g_hn
            // Horner step: p = c - t2*p
            assign prod = r_st[k-1].t2 * r_st[k-1].p;
            always_ff @(posedge i_clk) begin
                r_st[k].t   <= r_st[k-1].t;
                r_st[k].t2  <= r_st[k-1].t2;
                r_st[k].p   <= SIN_COEF[k-1] - prod[60:30];
                r_st[k].neg <= r_st[k-1].neg;
            end
        end
    end

    logic [61:0] fin_prod;
    logic [31:0] fin_p;

    assign fin_prod = r_st[SIN_HORNER+1].t * r_st[SIN_HORNER+1].p;
    assign fin_p    = fin_prod[61:30];

    // Clamp to one
    always_ff @(posedge i_clk) begin
        r_mag <= (fin_p > {1'b0, Q30_ONE}) ? Q30_ONE : fin_p[30:0];
        r_neg <= r_st[SIN_HORNER+1].neg;
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for uv_sphere_tessellator_unit: vertex and quad requests checked
// against an in-bench fixed-point predictor. Depends on uvs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import uvs_pkg::*;

    typedef struct packed {
        logic        func;
        logic [15:0] index;
        logic        cfg_we;   // configuration write instead of a request
        logic        cfg_idx;
        logic [15:0] cfg_data;
    } t_job;

    typedef struct packed {
        logic [16:0] px, py, pz;
        logic [15:0] tu, tv;
        logic [15:0] c0, c1, c2, c3, c4, c5;
        logic        oor;
    } t_mesh_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [IDX_W-1:0]  i_item_index;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [TEX_W-1:0]  o_tex_u, o_tex_v;
    logic [IDX_W-1:0]  o_corner_0, o_corner_1, o_corner_2;
    logic [IDX_W-1:0]  o_corner_3, o_corner_4, o_corner_5;
    logic              o_out_of_range;

    uv_sphere_tessellator_unit i_dut (.*);

    t_job      job_q[$];
    t_mesh_res mesh_expected_q[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        stim_done = 0;
    int        gap_left = 0;
    int        idle_hold = 0;

    // predictor copy of the two registers
    logic [15:0] pred_radius;
    logic [7:0]  pred_segments;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sine of a phase in 2^-32 turn: Q30 magnitude, sign
    function automatic void phase_sine(input logic [31:0] ph, output logic [63:0] mag,
                                       output bit neg);
        logic [63:0] f, t, t2, p;
        f = {34'd0, ph[29:0]};
        t = ph[30] ? (64'd1073741824 - f) : f;
        t2 = (t * t) >> 30;
        p = 64'd3864;
        p = 64'd172272 - ((t2 * p) >> 30);
        p = 64'd5026995 - ((t2 * p) >> 30);
        p = 64'd85569306 - ((t2 * p) >> 30);
        p = 64'd693598668 - ((t2 * p) >> 30);
        p = 64'd1686629713 - ((t2 * p) >> 30);
        p = (t * p) >> 30;
        if (p > 64'd1073741824) p = 64'd1073741824;
        mag = p;
        neg = ph[31];
    endfunction

    function automatic logic [63:0] round_q30(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    function automatic logic [16:0] signed_pos(logic [63:0] mag, bit neg);
        logic [16:0] m;
        m = mag[16:0];
        return neg ? (17'd0 - m) : m;
    endfunction

    function automatic t_mesh_res tessellate(logic func, logic [15:0] index);
        t_mesh_res   res;
        logic [63:0] s, cnt, col, row, r, ca, sa, sp, cp, w, a;
        logic [31:0] az, pol;
        bit          nca, nsa, nsp, ncp;
        res = '0;
        s = (pred_segments < 2) ? 64'd2 : 64'(pred_segments);
        cnt = s + 1;
        if (func == FUNC_VERTEX) begin
            if (index >= cnt * cnt) begin
                res.oor = 1'b1;
                return res;
            end
            col = index % cnt;
            row = index / cnt;
            r = 64'(pred_radius);
            res.tu = 16'((col * 32768 + s / 2) / s);
            res.tv = 16'((row * 32768 + s / 2) / s);
            az = 32'(((col << 32) + s / 2) / s);
            pol = 32'(((row << 31) + s / 2) / s);
            phase_sine(az, sa, nsa);
            phase_sine(az + 32'h4000_0000, ca, nca);
            phase_sine(pol, sp, nsp);
            phase_sine(pol + 32'h4000_0000, cp, ncp);
            w = round_q30(ca, sp);
            res.px = signed_pos(round_q30(r, w), !(nca != nsp));
            res.py = signed_pos(round_q30(r, cp), ncp);
            w = round_q30(sa, sp);
            res.pz = signed_pos(round_q30(r, w), nsa != nsp);
        end else begin
            if (index >= s * s) begin
                res.oor = 1'b1;
                return res;
            end
            a = (index / s) * cnt + index % s;
            res.c0 = 16'(a + 1);
            res.c1 = 16'(a);
            res.c2 = 16'(a + cnt + 1);
            res.c3 = 16'(a);
            res.c4 = 16'(a + cnt);
            res.c5 = 16'(a + cnt + 1);
        end
        return res;
    endfunction

    task automatic add_request(logic func, logic [15:0] index);
        job_q.push_back('{func: func, index: index, cfg_we: 1'b0, cfg_idx: 1'b0,
                          cfg_data: 16'd0});
    endtask

    task automatic add_config(t_cfg_reg idx, logic [15:0] data);
        job_q.push_back('{func: 1'b0, index: 16'd0, cfg_we: 1'b1, cfg_idx: idx,
                          cfg_data: data});
    endtask

    // Random requests for the current geometry: mostly in range, some past the end
    task automatic add_random_batch(int n, int s);
        int lim;
        for (int k = 0; k < n; k++) begin
            logic f;
            f = $urandom_range(0, 1);
            lim = f ? s * s : (s + 1) * (s + 1);
            case ($urandom_range(0, 9))
                0:       add_request(f, 16'($urandom_range(0, 65535)));
                1:       add_request(f, 16'(lim + $urandom_range(0, 3)));
                default: add_request(f, 16'($urandom_range(0, lim - 1)));
            endcase
        end
    endtask

    // Fill the request queue: directed part, then random phases between config writes
    initial begin
        int segs;
        // directed, reset geometry: extremes and the edges of the index range
        add_request(FUNC_VERTEX, 16'd0);
        add_request(FUNC_VERTEX, 16'd8);
        add_request(FUNC_VERTEX, 16'd144);
        add_request(FUNC_VERTEX, 16'd288);
        add_request(FUNC_VERTEX, 16'd289);
        add_request(FUNC_VERTEX, 16'hFFFF);
        add_request(FUNC_QUAD, 16'd0);
        add_request(FUNC_QUAD, 16'd255);
        add_request(FUNC_QUAD, 16'd256);
        add_request(FUNC_QUAD, 16'hFFFF);
        // degenerate segment counts act as two
        add_config(CFG_SEGMENTS, 16'd0);
        add_config(CFG_RADIUS, 16'hFFFF);
        add_request(FUNC_VERTEX, 16'd4);
        add_request(FUNC_VERTEX, 16'd8);
        add_request(FUNC_VERTEX, 16'd9);
        add_request(FUNC_QUAD, 16'd3);
        add_request(FUNC_QUAD, 16'd4);
        add_config(CFG_SEGMENTS, 16'd1);
        add_request(FUNC_VERTEX, 16'd5);
        add_config(CFG_SEGMENTS, 16'd255);
        add_config(CFG_RADIUS, 16'd0);
        add_request(FUNC_VERTEX, 16'd65535);
        add_request(FUNC_VERTEX, 16'd1000);
        add_request(FUNC_QUAD, 16'd65024);
        add_request(FUNC_QUAD, 16'd65025);
        add_config(CFG_RADIUS, 16'hFFFF);
        add_request(FUNC_VERTEX, 16'd65535);
        add_request(FUNC_VERTEX, 16'd32767);
        // random phases
        for (int ph = 0; ph < 24; ph++) begin
            case (ph % 4)
                0:       segs = $urandom_range(0, 8);
                1:       segs = $urandom_range(250, 255);
                default: segs = $urandom_range(0, 255);
            endcase
            add_config(CFG_SEGMENTS, 16'(segs));
            add_config(CFG_RADIUS, (ph % 5 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            add_random_batch(80, (segs < 2) ? 2 : segs);
        end
        stim_done = 1;
    end

    // Driver: issue requests, hold config writes until nothing is in flight
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_func <= 1'b0;
            i_item_index <= '0;
            i_cfg_we <= 1'b0;
            i_cfg_idx <= 1'b0;
            i_cfg_data <= '0;
            gap_left <= 0;
            idle_hold <= 0;
            pred_radius = RADIUS_RST;
            pred_segments = SEG_RST;
        end else begin
            if (start && !busy) begin
                mesh_expected_q.push_back(tessellate(i_func, i_item_index));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RADIUS) pred_radius = i_cfg_data;
                else pred_segments = i_cfg_data[7:0];
            end
            i_cfg_we <= 1'b0;
            if (start && busy) begin
                // hold the current request
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (job_q.size() == 0) begin
                start <= 1'b0;
            end else if (job_q[0].cfg_we) begin
                start <= 1'b0;
                // drain the pipeline, then let the latency pass before writing
                if (mesh_expected_q.size() != 0 || (start && !busy)) begin
                    idle_hold <= 0;
                end else if (idle_hold < LATENCY + 4) begin
                    idle_hold <= idle_hold + 1;
                end else begin
                    t_job j;
                    j = job_q.pop_front();
                    i_cfg_we <= 1'b1;
                    i_cfg_idx <= j.cfg_idx;
                    i_cfg_data <= j.cfg_data;
                    idle_hold <= 0;
                end
            end else begin
                t_job j;
                j = job_q.pop_front();
                start <= 1'b1;
                i_func <= j.func;
                i_item_index <= j.index;
                // mostly back to back, sometimes short gaps, rarely long ones
                case ($urandom_range(0, 19))
                    0:       gap_left <= $urandom_range(10, 40);
                    1, 2, 3: gap_left <= $urandom_range(1, 3);
                    default: gap_left <= 0;
                endcase
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (mesh_expected_q.size() == 0) begin
                $error("result strobe with nothing expected");
                fail_count <= fail_count + 1;
            end else begin
                t_mesh_res e;
                t_mesh_res g;
                e = mesh_expected_q.pop_front();
                g = '{o_pos_x, o_pos_y, o_pos_z, o_tex_u, o_tex_v, o_corner_0,
                      o_corner_1, o_corner_2, o_corner_3, o_corner_4, o_corner_5,
                      o_out_of_range};
                if (g !== e) begin
                    if (g.px !== e.px) $error("pos_x exp %0d got %0d", $signed(e.px), $signed(g.px));
                    if (g.py !== e.py) $error("pos_y exp %0d got %0d", $signed(e.py), $signed(g.py));
                    if (g.pz !== e.pz) $error("pos_z exp %0d got %0d", $signed(e.pz), $signed(g.pz));
                    if (g.tu !== e.tu) $error("tex_u exp %0d got %0d", e.tu, g.tu);
                    if (g.tv !== e.tv) $error("tex_v exp %0d got %0d", e.tv, g.tv);
                    if (g.c0 !== e.c0) $error("corner_0 exp %0d got %0d", e.c0, g.c0);
                    if (g.c1 !== e.c1) $error("corner_1 exp %0d got %0d", e.c1, g.c1);
                    if (g.c2 !== e.c2) $error("corner_2 exp %0d got %0d", e.c2, g.c2);
                    if (g.c3 !== e.c3) $error("corner_3 exp %0d got %0d", e.c3, g.c3);
                    if (g.c4 !== e.c4) $error("corner_4 exp %0d got %0d", e.c4, g.c4);
                    if (g.c5 !== e.c5) $error("corner_5 exp %0d got %0d", e.c5, g.c5);
                    if (g.oor !== e.oor) $error("out_of_range exp %0d got %0d", e.oor, g.oor);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Timeout: far above the slowest correct run
    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && job_q.size() == 0 && !start && mesh_expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && mesh_expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
